// File: design/pbts_pkg.sv
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared types, codes and constants of the bitmap priority task scheduler.
// ----------------------------------------------------------------------------
package pbts_pkg;

   localparam int DEF_MAX_TASKS      = 16;
   localparam int DEF_NUM_PRIORITIES = 32;
   localparam logic [7:0] LOCK_MAX   = 8'd255;

   // request codes
   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0,
      REQ_SET    = 3'd1,
      REQ_SLEEP  = 3'd2,
      REQ_TICK   = 3'd3,
      REQ_YIELD  = 3'd4,
      REQ_LOCK   = 3'd5,
      REQ_UNLOCK = 3'd6,
      REQ_NONE   = 3'd7
   } req_code_type;

   // target state codes of a set state request
   localparam logic [1:0] NST_READY     = 2'd0;
   localparam logic [1:0] NST_BLOCKED   = 2'd1;
   localparam logic [1:0] NST_SUSPENDED = 2'd2;

   // task modes as held in the task table
   typedef enum logic [1:0] {
      MODE_DORMANT   = 2'd0,
      MODE_READY     = 2'd1,
      MODE_BLOCKED   = 2'd2,
      MODE_SUSPENDED = 2'd3
   } mode_type;

   // link field touched by a read-modify-write of another task's entry
   typedef enum logic [1:0] {
      OTH_RNEXT = 2'd0,
      OTH_RPREV = 2'd1,
      OTH_BNEXT = 2'd2
   } oth_kind_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SM0, S_SM1, S_WB,
      S_RR0, S_RR1, S_RR2, S_RI0,
      S_BR1, S_BR2, S_TK1, S_TK2,
      S_OTRD, S_OTMOD, S_PICK, S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  task_id;
      logic [4:0]  priority_req;
      logic [1:0]  target_state;
      logic [31:0] sleep_ticks;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  run_task;
      logic        current_valid;
      logic        switched;
      logic [31:0] tick_count;
      logic [31:0] ready_mask;
      logic        locked;
   } rsp_word_type;

endpackage

// File: design/pbts_task_ram.sv
// ----------------------------------------------------------------------------
// pbts_task_ram
// Per-task table: one write and one registered read per cycle, with a
// written flag per entry so that unwritten entries can read as reset values.
// ----------------------------------------------------------------------------
module pbts_task_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   output logic          rd_written
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [DW-1:0]    rd_data_ff;
   logic             rd_written_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_written = rd_written_ff;

endmodule

// File: design/priority_bitmap_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler_core
// Bitmap priority task scheduler around a per-task table memory.
//
// Usage: a request word enters on req_valid/req_ready; each request yields
// exactly one response word on rsp_valid/rsp_ready carrying the current task,
// tick counter, ready bitmap and lock flag after that request.
// One request is worked on at a time by a sequencer that reads, modifies and
// writes back task entries through a registered table read. Set state walks
// the blocked list when the task leaves blocked; a tick walks the whole
// blocked list and relinks each task it wakes, so the blocked-list walk sets
// the worst case.
// The response sits in an output register: while the receiver stalls the
// next request is still taken and worked on, and waits only to present its
// own word. Reset makes task 0 ready at priority 0, no task current, counter
// and lock depth zero; the first request is taken the cycle after reset.
// ----------------------------------------------------------------------------
module priority_bitmap_task_scheduler_core
   import pbts_pkg::*;
#(
   parameter int MAX_TASKS      = DEF_MAX_TASKS,
   parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int TW = $clog2(MAX_TASKS);
   localparam int LW = TW + 1;
   localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam logic [LW-1:0] NULL_LINK = {1'b1, {TW{1'b0}}};

   typedef struct packed {
      logic [4:0]    prio;
      mode_type      mode;
      logic [31:0]   wake;
      logic [LW-1:0] rnext;
      logic [LW-1:0] rprev;
      logic [LW-1:0] bnext;
   } ent_type;

   localparam int EW = $bits(ent_type);

   function automatic logic [PW-1:0] top_prio(input logic [NUM_PRIORITIES-1:0] b);
      logic [PW-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
         if (b[i]) begin
            r = PW'(i);
         end
      end
      return r;
   endfunction

   fsm_state_type state_ff, state_in, cont_ff, cont_in, ret_ff, ret_in;
   req_word_type  req_ff, req_in;
   ent_type       tent_ff, tent_in, ent_rd, ram_rd;
   logic [TW-1:0] tent_addr_ff, tent_addr_in;
   mode_type      mode_tgt_ff, mode_tgt_in;
   logic [TW-1:0] oth_addr_ff, oth_addr_in;
   oth_kind_type  oth_kind_ff, oth_kind_in;
   logic [LW-1:0] oth_val_ff, oth_val_in;
   logic [LW-1:0] wcur_ff, wcur_in, wprev_ff, wprev_in;
   logic [LW-1:0] bhead_ff, bhead_in, running_ff, running_in, before_ff, before_in;
   logic [31:0]   tick_ff, tick_in;
   logic [7:0]    lock_ff, lock_in;
   logic [NUM_PRIORITIES-1:0] rbits_ff, rbits_in;
   logic [LW-1:0] heads_ff [NUM_PRIORITIES];
   rsp_word_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rd_zero_ff;

   logic          rd_en, wr_en, head_we, rd_written;
   logic [TW-1:0] rd_addr, wr_addr;
   ent_type       wr_data, oth_ent;
   logic [PW-1:0] head_wa, pidx, hi_p;
   logic [LW-1:0] head_wd, hlink;
   logic          tid_ok;
   mode_type      set_tgt;
   logic [4:0]    prio_sat;
   logic [EW-1:0] ram_rd_bits;

   pbts_task_ram #(
      .DEPTH (MAX_TASKS),
      .AW    (TW),
      .DW    (EW)
   ) u_ram (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (ram_rd_bits),
      .rd_written (rd_written)
   );

   assign ram_rd = ent_type'(ram_rd_bits);

   // entries never written read as their reset value
   always_comb begin
      ent_rd = ram_rd;
      if (!rd_written) begin
         ent_rd.prio  = 5'd0;
         ent_rd.mode  = rd_zero_ff ? MODE_READY : MODE_DORMANT;
         ent_rd.wake  = 32'd0;
         ent_rd.rnext = NULL_LINK;
         ent_rd.rprev = NULL_LINK;
         ent_rd.bnext = NULL_LINK;
      end
   end

   // request decode helpers
   assign tid_ok   = 32'(req_ff.task_id) < 32'(MAX_TASKS);
   assign prio_sat = (32'(req_ff.priority_req) >= 32'(NUM_PRIORITIES)) ?
                     5'(NUM_PRIORITIES - 1) : req_ff.priority_req;
   assign pidx     = PW'(tent_ff.prio);
   assign hi_p     = top_prio(rbits_ff);

   always_comb begin
      case (req_ff.target_state)
         NST_READY:     set_tgt = MODE_READY;
         NST_BLOCKED:   set_tgt = MODE_BLOCKED;
         NST_SUSPENDED: set_tgt = MODE_SUSPENDED;
         default:       set_tgt = MODE_DORMANT;
      endcase
   end

   // modified copy of another task's entry
   always_comb begin
      oth_ent = ent_rd;
      case (oth_kind_ff)
         OTH_RNEXT: oth_ent.rnext = oth_val_ff;
         OTH_RPREV: oth_ent.rprev = oth_val_ff;
         OTH_BNEXT: oth_ent.bnext = oth_val_ff;
         default:   oth_ent = ent_rd;
      endcase
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      cont_in      = cont_ff;
      ret_in       = ret_ff;
      req_in       = req_ff;
      tent_in      = tent_ff;
      tent_addr_in = tent_addr_ff;
      mode_tgt_in  = mode_tgt_ff;
      oth_addr_in  = oth_addr_ff;
      oth_kind_in  = oth_kind_ff;
      oth_val_in   = oth_val_ff;
      wcur_in      = wcur_ff;
      wprev_in     = wprev_ff;
      bhead_in     = bhead_ff;
      running_in   = running_ff;
      before_in    = before_ff;
      tick_in      = tick_ff;
      lock_in      = lock_ff;
      rbits_in     = rbits_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = tent_addr_ff;
      wr_data      = tent_ff;
      head_we      = 1'b0;
      head_wa      = pidx;
      head_wd      = NULL_LINK;
      hlink        = heads_ff[pidx];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_word;
               before_in = running_ff;
               rd_en     = 1'b1;
               rd_addr   = (req_word.req_type == REQ_SLEEP) ? running_ff[TW-1:0] :
                           TW'(req_word.task_id);
               tent_addr_in = rd_addr;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            tent_in  = ent_rd;
            state_in = S_DONE;
            case (req_code_type'(req_ff.req_type))
               REQ_CREATE: begin
                  if (tid_ok && ent_rd.mode == MODE_DORMANT) begin
                     tent_in.prio = prio_sat;
                     tent_in.mode = MODE_READY;
                     cont_in      = S_DONE;
                     state_in     = S_RI0;
                  end
               end
               REQ_SET: begin
                  if (tid_ok && set_tgt != MODE_DORMANT && ent_rd.mode != MODE_DORMANT
                      && ent_rd.mode != set_tgt) begin
                     mode_tgt_in = set_tgt;
                     cont_in     = S_DONE;
                     state_in    = S_SM0;
                  end
               end
               REQ_SLEEP: begin
                  if (!running_ff[TW] && req_ff.sleep_ticks != 32'd0 &&
                      ent_rd.mode == MODE_READY) begin
                     tent_in.wake  = tick_ff + req_ff.sleep_ticks;
                     tent_in.bnext = bhead_ff;
                     bhead_in      = {1'b0, tent_addr_ff};
                     mode_tgt_in   = MODE_BLOCKED;
                     cont_in       = S_PICK;
                     state_in      = S_SM0;
                  end
               end
               REQ_TICK: begin
                  tick_in  = tick_ff + 32'd1;
                  wcur_in  = bhead_ff;
                  wprev_in = NULL_LINK;
                  state_in = S_TK1;
               end
               REQ_YIELD: state_in = S_PICK;
               REQ_LOCK: begin
                  if (lock_ff != LOCK_MAX) begin
                     lock_in = lock_ff + 8'd1;
                  end
               end
               REQ_UNLOCK: begin
                  if (lock_ff != 8'd0) begin
                     lock_in = lock_ff - 8'd1;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         // leave the old mode
         S_SM0: begin
            if (tent_ff.mode == MODE_READY) begin
               state_in = S_RR0;
            end else if (tent_ff.mode == MODE_BLOCKED) begin
               wcur_in  = bhead_ff;
               wprev_in = NULL_LINK;
               state_in = S_BR1;
            end else begin
               state_in = S_SM1;
            end
         end
         // enter the new mode
         S_SM1: begin
            tent_in.mode = mode_tgt_ff;
            state_in     = (mode_tgt_ff == MODE_READY) ? S_RI0 : S_WB;
         end
         S_WB: begin
            wr_en    = 1'b1;
            state_in = cont_ff;
         end
         // ready list unlink: predecessor side
         S_RR0: begin
            if (!tent_ff.rprev[TW]) begin
               oth_addr_in = tent_ff.rprev[TW-1:0];
               oth_kind_in = OTH_RNEXT;
               oth_val_in  = tent_ff.rnext;
               ret_in      = S_RR1;
               state_in    = S_OTRD;
            end else begin
               head_we = 1'b1;
               head_wd = tent_ff.rnext;
               if (tent_ff.rnext[TW]) begin
                  rbits_in[pidx] = 1'b0;
               end
               state_in = S_RR1;
            end
         end
         // ready list unlink: successor side
         S_RR1: begin
            if (!tent_ff.rnext[TW]) begin
               oth_addr_in = tent_ff.rnext[TW-1:0];
               oth_kind_in = OTH_RPREV;
               oth_val_in  = tent_ff.rprev;
               ret_in      = S_RR2;
               state_in    = S_OTRD;
            end else begin
               state_in = S_RR2;
            end
         end
         S_RR2: begin
            tent_in.rnext = NULL_LINK;
            tent_in.rprev = NULL_LINK;
            state_in      = S_SM1;
         end
         // ready list insert at head
         S_RI0: begin
            tent_in.rnext  = hlink;
            tent_in.rprev  = NULL_LINK;
            head_we        = 1'b1;
            head_wd        = {1'b0, tent_addr_ff};
            rbits_in[pidx] = 1'b1;
            if (!hlink[TW]) begin
               oth_addr_in = hlink[TW-1:0];
               oth_kind_in = OTH_RPREV;
               oth_val_in  = {1'b0, tent_addr_ff};
               ret_in      = S_WB;
               state_in    = S_OTRD;
            end else begin
               state_in = S_WB;
            end
         end
         // blocked list search and unlink
         S_BR1: begin
            if (wcur_ff[TW]) begin
               state_in = S_SM1;
            end else if (wcur_ff[TW-1:0] == tent_addr_ff) begin
               tent_in.bnext = NULL_LINK;
               if (!wprev_ff[TW]) begin
                  oth_addr_in = wprev_ff[TW-1:0];
                  oth_kind_in = OTH_BNEXT;
                  oth_val_in  = tent_ff.bnext;
                  ret_in      = S_SM1;
                  state_in    = S_OTRD;
               end else begin
                  bhead_in = tent_ff.bnext;
                  state_in = S_SM1;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = wcur_ff[TW-1:0];
               state_in = S_BR2;
            end
         end
         S_BR2: begin
            wprev_in = wcur_ff;
            wcur_in  = ent_rd.bnext;
            state_in = S_BR1;
         end
         // tick walk over the blocked list
         S_TK1: begin
            if (wcur_ff[TW]) begin
               state_in = (lock_ff == 8'd0) ? S_PICK : S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = wcur_ff[TW-1:0];
               state_in = S_TK2;
            end
         end
         S_TK2: begin
            wcur_in = ent_rd.bnext;
            if (tick_ff >= ent_rd.wake) begin
               tent_in       = ent_rd;
               tent_in.bnext = NULL_LINK;
               tent_in.mode  = MODE_READY;
               tent_addr_in  = wcur_ff[TW-1:0];
               cont_in       = S_TK1;
               if (!wprev_ff[TW]) begin
                  oth_addr_in = wprev_ff[TW-1:0];
                  oth_kind_in = OTH_BNEXT;
                  oth_val_in  = ent_rd.bnext;
                  ret_in      = S_RI0;
                  state_in    = S_OTRD;
               end else begin
                  bhead_in = ent_rd.bnext;
                  state_in = S_RI0;
               end
            end else begin
               wprev_in = wcur_ff;
               state_in = S_TK1;
            end
         end
         // read-modify-write of another entry
         S_OTRD: begin
            rd_en    = 1'b1;
            rd_addr  = oth_addr_ff;
            state_in = S_OTMOD;
         end
         S_OTMOD: begin
            wr_en    = 1'b1;
            wr_addr  = oth_addr_ff;
            wr_data  = oth_ent;
            state_in = ret_ff;
         end
         // head of highest ready priority becomes current
         S_PICK: begin
            if (rbits_ff != '0 && heads_ff[hi_p] != running_ff) begin
               running_in = heads_ff[hi_p];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.current_valid = !running_ff[TW];
               rsp_in.run_task      = running_ff[TW] ? 4'd0 : 4'(running_ff[TW-1:0]);
               rsp_in.switched      = running_ff != before_ff;
               rsp_in.tick_count    = tick_ff;
               rsp_in.ready_mask    = 32'(rbits_ff);
               rsp_in.locked        = lock_ff != 8'd0;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bhead_ff     <= NULL_LINK;
         running_ff   <= NULL_LINK;
         tick_ff      <= 32'd0;
         lock_ff      <= 8'd0;
         rbits_ff     <= NUM_PRIORITIES'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            heads_ff[i] <= (i == 0) ? '0 : NULL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         bhead_ff     <= bhead_in;
         running_ff   <= running_in;
         tick_ff      <= tick_in;
         lock_ff      <= lock_in;
         rbits_ff     <= rbits_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            heads_ff[head_wa] <= head_wd;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cont_ff      <= cont_in;
      ret_ff       <= ret_in;
      req_ff       <= req_in;
      tent_ff      <= tent_in;
      tent_addr_ff <= tent_addr_in;
      mode_tgt_ff  <= mode_tgt_in;
      oth_addr_ff  <= oth_addr_in;
      oth_kind_ff  <= oth_kind_in;
      oth_val_ff   <= oth_val_in;
      wcur_ff      <= wcur_in;
      wprev_ff     <= wprev_in;
      before_ff    <= before_in;
      rsp_ff       <= rsp_in;
      rd_zero_ff   <= (rd_addr == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // the sequencer never reads an entry in the cycle it writes it
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("task table read and write collide");

   // a current task always lies inside the table
   a_running_range: assert property (@(posedge clock) disable iff (reset)
      !running_ff[TW] |-> (32'(running_ff[TW-1:0]) < 32'(MAX_TASKS)))
      else $error("current task out of range");

   // an accepted word starts work at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted word not dispatched");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap priority task scheduler: a directed table
// then random request words, each response checked against a local scheduler
// model, with sender and receiver idling in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb
   import pbts_pkg::*;
();

   localparam int NT = 16;
   localparam int NP = 32;
   localparam logic [4:0] NULL_ID = 5'h1f;
   localparam int WATCH_LIMIT = 20000;
   localparam int HOLD_LEN = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   priority_bitmap_task_scheduler_core i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scheduler model state
   logic [4:0]  t_prio [NT];
   mode_type    t_mode [NT];
   logic [31:0] t_wake [NT];
   logic [4:0]  r_next [NT];
   logic [4:0]  r_prev [NT];
   logic [4:0]  b_next [NT];
   logic [4:0]  r_head [NP];
   logic [31:0] r_bits;
   logic [4:0]  b_head;
   logic [4:0]  running;
   logic [31:0] ticks;
   logic [7:0]  lock_lvl;

   rsp_word_type expected_rsp [$];
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   int quiet_cycles = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void sched_reset();
      for (int i = 0; i < NT; i++) begin
         t_prio[i] = '0; t_mode[i] = MODE_DORMANT; t_wake[i] = '0;
         r_next[i] = NULL_ID; r_prev[i] = NULL_ID; b_next[i] = NULL_ID;
      end
      for (int i = 0; i < NP; i++) r_head[i] = NULL_ID;
      t_mode[0] = MODE_READY;
      r_head[0] = 5'd0;
      r_bits = 32'd1;
      b_head = NULL_ID;
      running = NULL_ID;
      ticks = '0;
      lock_lvl = '0;
   endfunction

   function automatic void ready_push(logic [4:0] t);
      logic [4:0] h;
      h = r_head[t_prio[t]];
      r_next[t] = h;
      r_prev[t] = NULL_ID;
      if (h < NT) r_prev[h] = t;
      r_head[t_prio[t]] = t;
      r_bits[t_prio[t]] = 1'b1;
   endfunction

   function automatic void ready_unlink(logic [4:0] t);
      logic [4:0] n, v;
      n = r_next[t];
      v = r_prev[t];
      if (v < NT) r_next[v] = n;
      else r_head[t_prio[t]] = n;
      if (n < NT) r_prev[n] = v;
      r_next[t] = NULL_ID;
      r_prev[t] = NULL_ID;
      if (r_head[t_prio[t]] == NULL_ID) r_bits[t_prio[t]] = 1'b0;
   endfunction

   function automatic void blocked_unlink(logic [4:0] t);
      logic [4:0] c, p;
      c = b_head;
      p = NULL_ID;
      for (int g = 0; g < NT && c < NT; g++) begin
         if (c == t) begin
            if (p < NT) b_next[p] = b_next[c];
            else b_head = b_next[c];
            b_next[c] = NULL_ID;
            return;
         end
         p = c;
         c = b_next[c];
      end
   endfunction

   function automatic void change_mode(logic [4:0] t, mode_type m);
      if (t_mode[t] == m) return;
      if (t_mode[t] == MODE_READY) ready_unlink(t);
      else if (t_mode[t] == MODE_BLOCKED) blocked_unlink(t);
      t_mode[t] = m;
      if (m == MODE_READY) ready_push(t);
   endfunction

   function automatic void choose_task();
      for (int p = NP - 1; p >= 0; p--) begin
         if (r_bits[p]) begin
            if (r_head[p] < NT) running = r_head[p];
            return;
         end
      end
   endfunction

   // applies one request to the model and returns the response word
   function automatic rsp_word_type schedule(req_word_type w);
      rsp_word_type r;
      logic [4:0] was, c, p, nx;
      was = running;
      case (req_code_type'(w.req_type))
         REQ_CREATE: if (t_mode[w.task_id] == MODE_DORMANT) begin
            t_prio[w.task_id] = w.priority_req;
            t_mode[w.task_id] = MODE_READY;
            ready_push({1'b0, w.task_id});
         end
         REQ_SET: if (w.target_state != 2'd3 && t_mode[w.task_id] != MODE_DORMANT) begin
            case (w.target_state)
               NST_READY:   change_mode({1'b0, w.task_id}, MODE_READY);
               NST_BLOCKED: change_mode({1'b0, w.task_id}, MODE_BLOCKED);
               default:     change_mode({1'b0, w.task_id}, MODE_SUSPENDED);
            endcase
         end
         REQ_SLEEP: if (running < NT && w.sleep_ticks != 0 &&
                        t_mode[running] == MODE_READY) begin
            c = running;
            t_wake[c] = ticks + w.sleep_ticks;
            change_mode(c, MODE_BLOCKED);
            b_next[c] = b_head;
            b_head = c;
            choose_task();
         end
         REQ_TICK: begin
            ticks++;
            c = b_head;
            p = NULL_ID;
            for (int g = 0; g < NT && c < NT; g++) begin
               nx = b_next[c];
               if (ticks >= t_wake[c]) begin
                  if (p < NT) b_next[p] = nx;
                  else b_head = nx;
                  b_next[c] = NULL_ID;
                  change_mode(c, MODE_READY);
               end else p = c;
               c = nx;
            end
            if (lock_lvl == 0) choose_task();
         end
         REQ_YIELD: choose_task();
         REQ_LOCK: if (lock_lvl != LOCK_MAX) lock_lvl++;
         REQ_UNLOCK: if (lock_lvl != 0) lock_lvl--;
         default: ;
      endcase
      r.current_valid = running < NT;
      r.run_task = r.current_valid ? running[3:0] : 4'd0;
      r.switched = running != was;
      r.tick_count = ticks;
      r.ready_mask = r_bits;
      r.locked = lock_lvl != 0;
      return r;
   endfunction

   // receiver: random stall, and a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_cnt <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // response checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCH_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
      if (rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            rsp_word_type e;
            e = expected_rsp.pop_front();
            if (rsp_word.run_task !== e.run_task)
               report("run_task", 32'(rsp_word.run_task), 32'(e.run_task));
            if (rsp_word.current_valid !== e.current_valid)
               report("current_valid", 32'(rsp_word.current_valid),
                      32'(e.current_valid));
            if (rsp_word.switched !== e.switched)
               report("switched", 32'(rsp_word.switched), 32'(e.switched));
            if (rsp_word.tick_count !== e.tick_count)
               report("tick_count", rsp_word.tick_count, e.tick_count);
            if (rsp_word.ready_mask !== e.ready_mask)
               report("ready_mask", rsp_word.ready_mask, e.ready_mask);
            if (rsp_word.locked !== e.locked)
               report("locked", 32'(rsp_word.locked), 32'(e.locked));
         end
      end
   end

   // offers one word and waits for acceptance; the expected response is
   // queued in the same step as acceptance; valid stays up for the next word
   task automatic send(req_word_type w);
      rsp_word_type e;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      e = schedule(w);
      expected_rsp.push_back(e);
   endtask

   // drops valid before the sender pauses
   task automatic quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_word_type mk(req_code_type op, int id, int pr, int st,
                                       logic [31:0] sl);
      req_word_type w;
      w.req_type = op;
      w.task_id = 4'(id);
      w.priority_req = 5'(pr);
      w.target_state = 2'(st);
      w.sleep_ticks = sl;
      return w;
   endfunction

   // mostly meaningful traffic, some raw noise
   function automatic req_word_type random_word();
      req_word_type w;
      int k;
      w.sleep_ticks = $urandom;
      {w.req_type, w.task_id, w.priority_req, w.target_state} = 14'($urandom);
      k = $urandom_range(99);
      if (k < 12) w.req_type = REQ_CREATE;
      else if (k < 30) w.req_type = REQ_SET;
      else if (k < 45) w.req_type = REQ_SLEEP;
      else if (k < 75) w.req_type = REQ_TICK;
      else if (k < 85) w.req_type = REQ_YIELD;
      else if (k < 91) w.req_type = REQ_LOCK;
      else if (k < 98) w.req_type = REQ_UNLOCK;
      if (w.req_type == REQ_SLEEP && $urandom_range(9) != 0)
         w.sleep_ticks = $urandom_range(6);
      if (w.req_type == REQ_SET && $urandom_range(9) != 0)
         w.target_state = 2'($urandom_range(2));
      return w;
   endfunction

   typedef struct {
      req_word_type w;
      logic         typed;
      rsp_word_type e;
   } step_row_type;

   step_row_type plan [$];

   task automatic add(req_word_type w, logic typed = 1'b0, rsp_word_type e = '0);
      step_row_type s;
      s.w = w; s.typed = typed; s.e = e;
      plan.push_back(s);
   endtask

   initial begin
      sched_reset();
      // directed table; the first rows carry responses typed in by hand
      add(mk(REQ_YIELD, 0, 0, 0, 0), 1'b1, '{4'd0, 1'b1, 1'b1, 32'd0, 32'd1, 1'b0});
      add(mk(REQ_UNLOCK, 0, 0, 0, 0), 1'b1, '{4'd0, 1'b1, 1'b0, 32'd0, 32'd1, 1'b0});
      add(mk(REQ_CREATE, 15, 31, 0, 0), 1'b1,
          '{4'd0, 1'b1, 1'b0, 32'd0, 32'h8000_0001, 1'b0});
      add(mk(REQ_CREATE, 15, 3, 0, 0));        // create of an existing task
      add(mk(REQ_TICK, 0, 0, 0, 0), 1'b1,
          '{4'd15, 1'b1, 1'b1, 32'd1, 32'h8000_0001, 1'b0});
      add(mk(REQ_CREATE, 1, 5, 0, 0));
      add(mk(REQ_CREATE, 2, 5, 0, 0));
      add(mk(REQ_SLEEP, 0, 0, 0, 0));          // zero ticks does nothing
      add(mk(REQ_SLEEP, 0, 0, 0, 2));
      add(mk(REQ_SET, 3, 0, 0, 0));            // dormant task ignored
      add(mk(REQ_SET, 2, 0, 3, 0));            // unknown state code
      add(mk(REQ_SET, 2, 0, NST_BLOCKED, 0));
      add(mk(REQ_SET, 1, 0, NST_SUSPENDED, 0));
      add(mk(REQ_YIELD, 0, 0, 0, 0));
      add(mk(REQ_LOCK, 0, 0, 0, 0));
      add(mk(REQ_TICK, 0, 0, 0, 0));
      add(mk(REQ_TICK, 0, 0, 0, 0));           // sleeper due, locked: no pick
      add(mk(REQ_UNLOCK, 0, 0, 0, 0));
      add(mk(REQ_SLEEP, 0, 0, 0, 32'hffff_ffff));
      add(mk(REQ_SET, 15, 0, NST_READY, 0));   // already ready, no change
      add(mk(REQ_SET, 1, 0, NST_READY, 0));
      add(mk(REQ_SET, 2, 0, NST_READY, 0));
      add(mk(REQ_NONE, 9, 17, 2, 32'h1234_5678));
      add(mk(REQ_YIELD, 0, 0, 0, 0));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         send(plan[i].w);
         if (plan[i].typed && expected_rsp[$] != plan[i].e)
            report("model row", i, 0);
      end
      // lock depth saturation, then release
      repeat (256) send(mk(REQ_LOCK, 0, 0, 0, 0));
      repeat (256) send(mk(REQ_UNLOCK, 0, 0, 0, 0));
      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1) ? 82 : (ph == 3) ? 7 : 0;
         recv_stall = (ph == 2) ? 82 : (ph == 3) ? 7 : 0;
         if (ph == 2) begin
            hold_asked++;
            // the block fills while the receiver holds off
            repeat (8) send(random_word());
         end
         repeat (190) send(random_word());
         // sender pauses until all responses are in
         quiet();
         while (expected_rsp.size() != 0) @(posedge clock);
      end
      recv_stall = 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
